FILE: src/utf8_to_utf16_transcoder_defines.svh
// Assertion macros shared by the UTF-8 to UTF-16 transcoder modules.
`ifndef UTF8_TO_UTF16_TRANSCODER_DEFINES_SVH
`define UTF8_TO_UTF16_TRANSCODER_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define U8U16_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define U8U16_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/u8u16_pkg.sv
// Types and constants shared by the UTF-8 to UTF-16 transcoder modules.
package u8u16_pkg;

    localparam int ADDR_W  = 3;
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = Q_AW + 1;

    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_END  = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    localparam logic [20:0] CP_BMP_MAX = 21'h00ffff;
    localparam logic [20:0] CP_MAX     = 21'h10ffff;
    localparam logic [20:0] CP_SUPP    = 21'h010000;
    localparam logic [15:0] SURR_HI    = 16'hd800;
    localparam logic [15:0] SURR_LO    = 16'hdc00;
    localparam logic [2:0]  LEAD4_MAX  = 3'h4;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
    } t_item;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        unit_valid;
        logic        done_res;
        logic [1:0]  status;
        logic [31:0] unit_count;
        logic        last;
    } t_result;

    // One decoded job: a single result, or a surrogate pair when pair is set.
    typedef struct packed {
        logic        pair;
        logic [15:0] unit_hi;
        logic [15:0] unit_lo;
        logic        unit_valid;
        logic        done_res;
        logic [1:0]  status;
        logic [31:0] unit_count;
    } t_job;

endpackage

FILE: src/u8u16_front.sv
// Front end: decodes UTF-8 bytes, keeps string state and issues result jobs.
module u8u16_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  u8u16_pkg::t_item   i_item,
    input  logic               i_term_mode,
    input  logic [15:0]        i_capacity,
    output logic               o_job_push,
    output u8u16_pkg::t_job    o_job
);

    logic [1:0]  r_pending, n_pending;
    logic [20:0] r_accum,   n_accum;
    logic [31:0] r_count,   n_count;
    logic        r_invalid, n_invalid;
    logic        r_overflow, n_overflow;

    logic [7:0]  b;
    logic [20:0] acc_sh;
    logic [20:0] fin_cp;
    logic [20:0] supp_v;
    logic        do_finish;
    logic        do_close;
    logic        append;
    logic        inv_eff;
    logic        big;
    logic        too_big;
    logic        do_take;
    logic        take_two;
    logic [32:0] sum;
    logic [31:0] cnt_sat;
    logic [31:0] cnt_after;
    logic        cap_ok;
    logic        fits;
    logic        emit;
    logic        ovf_set;
    logic [1:0]  close_st;

    always_comb begin
        b          = i_item.data_byte;
        n_pending  = r_pending;
        n_accum    = r_accum;
        n_count    = r_count;
        n_invalid  = r_invalid;
        n_overflow = r_overflow;
        do_finish  = 1'b0;
        do_close   = 1'b0;
        append     = 1'b0;
        fin_cp     = '0;
        acc_sh     = {r_accum[14:0], b[5:0]};
        o_job_push = 1'b0;
        o_job      = '0;

        // byte classification
        if (i_accept) begin
            if (i_item.cmd == u8u16_pkg::CMD_END) begin
                if (!i_term_mode) begin
                    do_close = 1'b1;
                end
            end else if (i_term_mode && b == 8'h00) begin
                do_close = 1'b1;
                append   = 1'b1;
            end else if (r_pending != 2'd0) begin
                if (b[7:6] != 2'b10) begin
                    // bad continuation: drop it and abandon the sequence
                    n_invalid = 1'b1;
                    n_pending = 2'd0;
                    n_accum   = '0;
                end else begin
                    n_pending = r_pending - 2'd1;
                    if (r_pending == 2'd1) begin
                        do_finish = 1'b1;
                        fin_cp    = acc_sh;
                        n_accum   = '0;
                    end else begin
                        n_accum = acc_sh;
                    end
                end
            end else if (b[7] == 1'b0) begin
                do_finish = 1'b1;
                fin_cp    = 21'(b);
            end else if (b[7:5] == 3'b110 && b[4:0] >= 5'd2) begin
                n_pending = 2'd1;
                n_accum   = 21'(b[4:0]);
            end else if (b[7:4] == 4'b1110) begin
                n_pending = 2'd2;
                n_accum   = 21'(b[3:0]);
            end else if (b[7:3] == 5'b11110 && b[2:0] <= u8u16_pkg::LEAD4_MAX) begin
                n_pending = 2'd3;
                n_accum   = 21'(b[2:0]);
            end else begin
                n_invalid = 1'b1;
            end
        end

        // unit accounting against the output buffer
        inv_eff   = do_close ? (r_invalid || r_pending != 2'd0) : r_invalid;
        big       = fin_cp > u8u16_pkg::CP_BMP_MAX;
        too_big   = fin_cp > u8u16_pkg::CP_MAX;
        do_take   = (do_finish && !too_big) || append;
        take_two  = do_finish && big;
        sum       = {1'b0, r_count} + (take_two ? 33'd2 : 33'd1);
        cnt_sat   = sum[32] ? '1 : sum[31:0];
        cap_ok    = !inv_eff && !r_overflow && i_capacity != 16'd0;
        fits      = sum <= {17'd0, i_capacity};
        emit      = do_take && cap_ok && fits;
        ovf_set   = do_take && cap_ok && !fits;
        cnt_after = do_take ? cnt_sat : r_count;
        supp_v    = fin_cp - u8u16_pkg::CP_SUPP;

        if (do_take) begin
            n_count = cnt_sat;
            if (ovf_set) begin
                n_overflow = 1'b1;
            end
        end
        if (do_finish && too_big) begin
            n_invalid = 1'b1;
        end

        if (do_finish && emit) begin
            o_job_push       = 1'b1;
            o_job.pair       = big;
            o_job.unit_hi    = big ? (u8u16_pkg::SURR_HI + 16'(supp_v[19:10])) : fin_cp[15:0];
            o_job.unit_lo    = u8u16_pkg::SURR_LO + 16'(supp_v[9:0]);
            o_job.unit_valid = 1'b1;
        end

        close_st = inv_eff ? u8u16_pkg::ST_INVALID :
                   ((r_overflow || ovf_set) ? u8u16_pkg::ST_OVERFLOW : u8u16_pkg::ST_OK);
        if (do_close) begin
            o_job_push       = 1'b1;
            o_job.unit_valid = emit && close_st == u8u16_pkg::ST_OK;
            o_job.done_res   = 1'b1;
            o_job.status     = close_st;
            o_job.unit_count = (close_st == u8u16_pkg::ST_OK) ? cnt_after : 32'd0;
            n_pending        = 2'd0;
            n_accum          = '0;
            n_count          = '0;
            n_invalid        = 1'b0;
            n_overflow       = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending  <= '0;
            r_accum    <= '0;
            r_count    <= '0;
            r_invalid  <= 1'b0;
            r_overflow <= 1'b0;
        end else begin
            r_pending  <= n_pending;
            r_accum    <= n_accum;
            r_count    <= n_count;
            r_invalid  <= n_invalid;
            r_overflow <= n_overflow;
        end
    end

endmodule

FILE: src/u8u16_queue.sv
// Job queue between the decode front end and the result back end.
`include "utf8_to_utf16_transcoder_defines.svh"

module u8u16_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  u8u16_pkg::t_job   i_job,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_valid,
    output u8u16_pkg::t_job   o_head
);

    u8u16_pkg::t_job              r_mem [u8u16_pkg::Q_DEPTH];
    logic [u8u16_pkg::Q_AW-1:0]   r_wr_ptr;
    logic [u8u16_pkg::Q_AW-1:0]   r_rd_ptr;
    logic [u8u16_pkg::Q_CW-1:0]   r_count;

    assign o_full  = r_count == u8u16_pkg::Q_CW'(u8u16_pkg::Q_DEPTH);
    assign o_valid = r_count != '0;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `U8U16_ASSERT(a_q_no_overrun, !(i_push && o_full && !i_pop), "job pushed into full queue")
    `U8U16_ASSERT(a_q_no_underrun, !(i_pop && !o_valid), "job popped from empty queue")

endmodule

FILE: src/u8u16_back.sv
// Back end: expands jobs into results and holds them in the output register.
`include "utf8_to_utf16_transcoder_defines.svh"

module u8u16_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    input  u8u16_pkg::t_job     i_job,
    input  logic                i_pop,
    output logic                o_job_pop,
    output logic                o_empty,
    output u8u16_pkg::t_result  o_result
);

    logic                r_valid;
    logic                r_half;
    u8u16_pkg::t_result  r_res;
    u8u16_pkg::t_result  n_res;
    logic                pop_acc;
    logic                load;
    logic                first_half;

    assign pop_acc    = i_pop && r_valid;
    assign load       = !r_valid || pop_acc;
    assign first_half = i_job.pair && !r_half;
    assign o_job_pop  = load && i_job_valid && !first_half;
    assign o_empty    = !r_valid;
    assign o_result   = r_res;

    always_comb begin
        n_res            = '0;
        n_res.code_unit  = (i_job.pair && r_half) ? i_job.unit_lo : i_job.unit_hi;
        n_res.unit_valid = i_job.unit_valid;
        n_res.done_res   = i_job.done_res;
        n_res.status     = i_job.status;
        n_res.unit_count = i_job.unit_count;
        n_res.last       = !first_half;
    end

    always_ff @(posedge i_clk) begin
        if (load && i_job_valid) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_half  <= 1'b0;
        end else if (load) begin
            r_valid <= i_job_valid;
            if (i_job_valid) begin
                r_half <= first_half;
            end
        end
    end

    `U8U16_ASSERT(a_bk_half_held, !r_half || (r_valid && i_job_valid && i_job.pair),
        "second half of pair lost")
    `U8U16_ASSERT_NEXT(a_bk_pair_follow, pop_acc && !r_res.last, r_valid && r_res.last,
        "second unit of pair not shown next")
    `U8U16_ASSERT(a_bk_done_last, !(r_valid && r_res.done_res && !r_res.last),
        "closing result not marked last")

endmodule

FILE: src/utf8_to_utf16_transcoder.sv
// UTF-8 to UTF-16 transcoder top level: config registers, front, job queue, back.
// An accepted byte's job goes into the job queue, then into the output register once that is free.
// Throughput: one byte per cycle unless the queue is full; a surrogate pair gives two results.
// The 4-entry job queue absorbs output stalls; full rises only when it fills up.
// Reset (i_rst_n low, synchronous): string state, queue and output clear; registers go to 0.
// Config registers: 0x0 terminated_mode (bit 0), 0x4 out_capacity (bits 15:0).
module utf8_to_utf16_transcoder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [u8u16_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    // byte input
    input  logic                            push,
    input  u8u16_pkg::t_item                i_item,
    output logic                            full,
    // result output
    output logic                            empty,
    input  logic                            pop,
    output u8u16_pkg::t_result              o_result
);

    logic               r_term_mode;
    logic [15:0]        r_capacity;
    logic               cfg_wr;
    logic               accept;
    logic               job_push;
    u8u16_pkg::t_job    job_in;
    logic               q_full;
    logic               q_valid;
    logic               q_pop;
    u8u16_pkg::t_job    q_head;

    // APB access: zero wait states, register picked by address bit 2
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = paddr[2] ? {16'd0, r_capacity} : {31'd0, r_term_mode};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term_mode <= 1'b0;
            r_capacity  <= '0;
        end else if (cfg_wr) begin
            if (paddr[2]) begin
                r_capacity <= pwdata[15:0];
            end else begin
                r_term_mode <= pwdata[0];
            end
        end
    end

    // a transaction is taken whenever the job queue has room
    assign full   = q_full;
    assign accept = push && !q_full;

    u8u16_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_item),
        .i_term_mode (r_term_mode),
        .i_capacity  (r_capacity),
        .o_job_push  (job_push),
        .o_job       (job_in)
    );

    u8u16_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    u8u16_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_head),
        .i_pop       (pop),
        .o_job_pop   (q_pop),
        .o_empty     (empty),
        .o_result    (o_result)
    );

endmodule

FILE: tb/sv/u8u16_tb_pkg.sv
// Register addresses of the transcoder shared by the testbench modules.
`timescale 1ns / 100ps
package u8u16_tb_pkg;

    localparam logic [u8u16_pkg::ADDR_W-1:0] REG_TERM_MODE = 'h0;
    localparam logic [u8u16_pkg::ADDR_W-1:0] REG_OUT_CAP   = 'h4;

endpackage

FILE: tb/sv/utf8_to_utf16_transcoder_checker.sv
// Scoreboard for the transcoder: tracks config writes, decodes bytes, checks each result.
`timescale 1ns / 100ps
module utf8_to_utf16_transcoder_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_psel,
    input  logic                            i_penable,
    input  logic                            i_pwrite,
    input  logic [u8u16_pkg::ADDR_W-1:0]    i_paddr,
    input  logic [31:0]                     i_pwdata,
    input  logic                            i_pready,
    input  logic                            i_push,
    input  logic                            i_full,
    input  u8u16_pkg::t_item                i_item,
    input  logic                            i_empty,
    input  logic                            i_pop,
    input  u8u16_pkg::t_result              i_result,
    output int                              o_fail_count,
    output int                              o_outstanding,
    output int                              o_compared
);
    import u8u16_pkg::*;
    import u8u16_tb_pkg::*;

    localparam logic [20:0] LAST_CODE_POINT = 21'h10ffff;
    localparam logic [20:0] BMP_TOP         = 21'h00ffff;
    localparam logic [20:0] SUPP_BASE       = 21'h010000;
    localparam logic [15:0] HI_SURR         = 16'hd800;
    localparam logic [15:0] LO_SURR         = 16'hdc00;

    // register copies
    bit          term_mode_q;
    logic [15:0] capacity_q;

    // per-string decode state
    logic [1:0]  cont_left;
    logic [20:0] code_point;
    logic [31:0] units_needed;
    bit          seq_bad;
    bit          buf_overrun;

    t_result     awaited_results[$];
    t_result     step_res[2];
    int          step_cnt;
    int          errors_seen = 0;
    int          compared    = 0;

    function automatic void clear_string_state();
        cont_left    = '0;
        code_point   = '0;
        units_needed = '0;
        seq_bad      = 1'b0;
        buf_overrun  = 1'b0;
    endfunction

    // Counts n units (saturating); returns 1 when they go out.
    function automatic bit reserve_units(int unsigned n);
        logic [31:0] prior;
        logic [32:0] wanted;
        bit          fits;
        prior = units_needed;
        fits  = 1'b0;
        if (units_needed > 32'hffff_ffff - n)
            units_needed = 32'hffff_ffff;
        else
            units_needed = units_needed + n;
        if (!seq_bad && !buf_overrun && capacity_q != 16'h0) begin
            wanted = {1'b0, prior} + 33'(n);
            if (wanted > {17'b0, capacity_q})
                buf_overrun = 1'b1;
            else
                fits = 1'b1;
        end
        return fits;
    endfunction

    function automatic void stage(logic [15:0] unit, bit valid, bit done,
                                  logic [1:0] st, logic [31:0] cnt);
        t_result r;
        r.code_unit  = unit;
        r.unit_valid = valid;
        r.done_res   = done;
        r.status     = st;
        r.unit_count = cnt;
        r.last       = 1'b0;
        step_res[step_cnt] = r;
        step_cnt++;
    endfunction

    function automatic void emit_code_point(logic [20:0] cp);
        logic [19:0] off;
        if (cp > LAST_CODE_POINT) begin
            seq_bad = 1'b1;
        end else if (cp > BMP_TOP) begin
            off = 20'(cp - SUPP_BASE);
            if (reserve_units(2)) begin
                stage(HI_SURR + {6'b0, off[19:10]}, 1'b1, 1'b0, ST_OK, 32'h0);
                stage(LO_SURR + {6'b0, off[9:0]}, 1'b1, 1'b0, ST_OK, 32'h0);
            end
        end else if (reserve_units(1)) begin
            stage(cp[15:0], 1'b1, 1'b0, ST_OK, 32'h0);
        end
    endfunction

    function automatic void close_string(bit add_zero);
        bit         unit_ok;
        logic [1:0] st;
        unit_ok = 1'b0;
        if (cont_left != 2'd0)
            seq_bad = 1'b1;
        if (add_zero) begin
            if (reserve_units(1))
                unit_ok = 1'b1;
        end
        st = seq_bad ? ST_INVALID : (buf_overrun ? ST_OVERFLOW : ST_OK);
        if (st != ST_OK)
            unit_ok = 1'b0;
        stage(16'h0, unit_ok, 1'b1, st, (st != ST_OK) ? 32'h0 : units_needed);
        clear_string_state();
    endfunction

    // Decodes one accepted input transaction and queues the results it causes.
    function automatic void transcode_item(t_item it);
        logic [7:0] b;
        int         k;
        b        = it.data_byte;
        step_cnt = 0;
        if (it.cmd == CMD_END) begin
            if (!term_mode_q)
                close_string(1'b0);
        end else if (term_mode_q && b == 8'h00) begin
            close_string(1'b1);
        end else if (cont_left != 2'd0) begin
            if (b[7:6] != 2'b10) begin
                // resync: drop the byte and the pending sequence
                seq_bad    = 1'b1;
                cont_left  = 2'd0;
                code_point = '0;
            end else begin
                code_point = {code_point[14:0], b[5:0]};
                cont_left  = cont_left - 2'd1;
                if (cont_left == 2'd0) begin
                    emit_code_point(code_point);
                    code_point = '0;
                end
            end
        end else if (!b[7]) begin
            emit_code_point({13'b0, b});
        end else if (b[7:5] == 3'b110 && b[4:0] >= 5'd2) begin
            cont_left  = 2'd1;
            code_point = {16'b0, b[4:0]};
        end else if (b[7:4] == 4'b1110) begin
            cont_left  = 2'd2;
            code_point = {17'b0, b[3:0]};
        end else if (b[7:3] == 5'b11110 && b[2:0] <= 3'd4) begin
            cont_left  = 2'd3;
            code_point = {18'b0, b[2:0]};
        end else begin
            seq_bad = 1'b1;
        end
        if (step_cnt > 0)
            step_res[step_cnt-1].last = 1'b1;
        for (k = 0; k < step_cnt; k++)
            awaited_results.push_back(step_res[k]);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        errors_seen++;
        $display("%0t: result mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            term_mode_q = 1'b0;
            capacity_q  = 16'h0;
            clear_string_state();
            awaited_results.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr == REG_TERM_MODE)
                    term_mode_q = i_pwdata[0];
                else if (i_paddr == REG_OUT_CAP)
                    capacity_q = i_pwdata[15:0];
            end
            // results leave before the new byte is decoded; latency keeps them apart
            if (i_pop && !i_empty) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("unexpected transaction", {16'h0, i_result.code_unit}, 32'h0);
                end else begin
                    want = awaited_results.pop_front();
                    compared++;
                    if (i_result.code_unit !== want.code_unit)
                        report_mismatch("code_unit", {16'h0, i_result.code_unit},
                                        {16'h0, want.code_unit});
                    if (i_result.unit_valid !== want.unit_valid)
                        report_mismatch("unit_valid", {31'h0, i_result.unit_valid},
                                        {31'h0, want.unit_valid});
                    if (i_result.done_res !== want.done_res)
                        report_mismatch("done_res", {31'h0, i_result.done_res},
                                        {31'h0, want.done_res});
                    if (i_result.status !== want.status)
                        report_mismatch("status", {30'h0, i_result.status}, {30'h0, want.status});
                    if (i_result.unit_count !== want.unit_count)
                        report_mismatch("unit_count", i_result.unit_count, want.unit_count);
                    if (i_result.last !== want.last)
                        report_mismatch("last", {31'h0, i_result.last}, {31'h0, want.last});
                end
            end
            if (i_push && !i_full)
                transcode_item(i_item);
        end
        o_fail_count  <= errors_seen;
        o_outstanding <= awaited_results.size();
        o_compared    <= compared;
    end

endmodule

FILE: tb/sv/utf8_to_utf16_transcoder_test.sv
// Top of the transcoder testbench: clock, reset, stimulus, output draining and verdict.
`timescale 1ns / 100ps
module utf8_to_utf16_transcoder_test;
    import u8u16_pkg::*;
    import u8u16_tb_pkg::*;

    localparam int          HOLD_OFF_CYCLES = 300;   // long output stall to fill the queue
    localparam int          SETTLE_CYCLES   = 6;     // margin after the last result is taken
    localparam int          RANDOM_ITEMS    = 600;
    localparam int          PHASE_ITEMS     = 60;
    localparam longint      RUN_LIMIT_NS    = 5_000_000;
    localparam logic [15:0] CAP_MAX         = 16'hffff;

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [ADDR_W-1:0]   paddr   = '0;
    logic [31:0]         pwdata  = '0;
    logic [31:0]         prdata;
    logic                pready;
    logic                push    = 1'b0;
    t_item               i_item  = '0;
    logic                full;
    logic                empty;
    logic                pop     = 1'b0;
    t_result             o_result;

    int fail_count;
    int outstanding;
    int compared;

    // stimulus bookkeeping
    bit term_now         = 1'b0;
    bit sender_steady    = 1'b0;
    int items_sent       = 0;
    int settings_used    = 0;
    int hold_offs_asked  = 0;
    int hold_offs_served = 0;

    always #5 i_clk = ~i_clk;

    utf8_to_utf16_transcoder DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .push     (push),
        .i_item   (i_item),
        .full     (full),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    utf8_to_utf16_transcoder_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_pready      (pready),
        .i_push        (push),
        .i_full        (full),
        .i_item        (i_item),
        .i_empty       (empty),
        .i_pop         (pop),
        .i_result      (o_result),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding),
        .o_compared    (compared)
    );

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap(bit steady);
        int roll;
        if (steady)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // One input transaction. push stays high on return; wait_idle lowers it.
    task automatic send_item(logic cmd, logic [7:0] b);
        int gap;
        if (items_sent % 32 == 0)
            sender_steady = ($urandom_range(0, 3) == 0);
        gap = pick_gap(sender_steady);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push             <= 1'b1;
        i_item.cmd       <= cmd;
        i_item.data_byte <= b;
        do @(posedge i_clk); while (full);
        // end commands in terminated mode are dropped by the block
        if (!(cmd == CMD_END && term_now))
            items_sent++;
    endtask

    // Waits until every predicted result has been taken, plus the pipeline latency.
    task automatic wait_idle();
        push <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup then access; psel is left up for back-to-back writes.
    task automatic write_reg(logic [ADDR_W-1:0] addr, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    task automatic apply_setting(bit term, logic [15:0] cap);
        wait_idle();
        write_reg(REG_TERM_MODE, {31'b0, term});
        write_reg(REG_OUT_CAP, {16'b0, cap});
        psel     <= 1'b0;
        penable  <= 1'b0;
        term_now  = term;
        settings_used++;
    endtask

    // UTF-8 encoding in a chosen length; lengths above the minimum give overlong forms.
    task automatic send_code_point(logic [20:0] cp, int width);
        case (width)
            1: send_item(CMD_DATA, {1'b0, cp[6:0]});
            2: begin
                send_item(CMD_DATA, {3'b110, cp[10:6]});
                send_item(CMD_DATA, {2'b10, cp[5:0]});
            end
            3: begin
                send_item(CMD_DATA, {4'b1110, cp[15:12]});
                send_item(CMD_DATA, {2'b10, cp[11:6]});
                send_item(CMD_DATA, {2'b10, cp[5:0]});
            end
            default: begin
                send_item(CMD_DATA, {5'b11110, cp[20:18]});
                send_item(CMD_DATA, {2'b10, cp[17:12]});
                send_item(CMD_DATA, {2'b10, cp[11:6]});
                send_item(CMD_DATA, {2'b10, cp[5:0]});
            end
        endcase
    endtask

    // One string: mostly well-formed characters, some noise, then the terminator.
    task automatic send_random_string();
        int          n_chars;
        int          pick;
        logic [20:0] cp;
        n_chars = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 30) : $urandom_range(0, 8);
        repeat (n_chars) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                send_item(CMD_DATA, 8'($urandom_range(term_now ? 1 : 0, 127)));
            end else if (pick < 48) begin
                send_code_point(21'($urandom_range(12'h080, 12'h7ff)), 2);
            end else if (pick < 68) begin
                // three-byte: overlong and surrogate values pass through
                if ($urandom_range(0, 3) == 0)
                    cp = 21'($urandom_range(16'hd800, 16'hdfff));
                else
                    cp = 21'($urandom_range(0, 16'hffff));
                send_code_point(cp, 3);
            end else if (pick < 84) begin
                if ($urandom_range(0, 7) == 0)
                    cp = 21'($urandom_range(0, 16'hffff));
                else
                    cp = 21'($urandom_range(17'h10000, 21'h10ffff));
                send_code_point(cp, 4);
            end else begin
                case ($urandom_range(0, 5))
                    0: send_item(CMD_DATA, 8'($urandom));
                    1: begin
                        // lead byte cut short by a plain character
                        send_item(CMD_DATA, 8'($urandom_range(8'hc2, 8'hf4)));
                        send_item(CMD_DATA, 8'($urandom_range(1, 127)));
                    end
                    2: send_item(CMD_DATA, 8'($urandom_range(8'h80, 8'hbf)));
                    3: begin
                        if ($urandom_range(0, 1) == 0)
                            send_item(CMD_DATA, 8'($urandom_range(8'hc0, 8'hc1)));
                        else
                            send_item(CMD_DATA, 8'($urandom_range(8'hf5, 8'hff)));
                    end
                    4: begin
                        // four-byte form above the last code point
                        send_item(CMD_DATA, 8'hf4);
                        send_item(CMD_DATA, 8'($urandom_range(8'h90, 8'hbf)));
                        send_item(CMD_DATA, 8'($urandom_range(8'h80, 8'hbf)));
                        send_item(CMD_DATA, 8'($urandom_range(8'h80, 8'hbf)));
                    end
                    default: begin
                        if (term_now)
                            send_item(CMD_END, 8'($urandom));
                        else
                            send_item(CMD_DATA, 8'h00);
                    end
                endcase
            end
        end
        // occasionally end the string in the middle of a sequence
        if (term_now) begin
            if ($urandom_range(0, 11) == 0)
                send_item(CMD_DATA, 8'he2);
            send_item(CMD_DATA, 8'h00);
        end else begin
            if ($urandom_range(0, 11) == 0)
                send_item(CMD_DATA, 8'hf0);
            send_item(CMD_END, 8'($urandom));
        end
    endtask

    // Output side: random pops, occasional no-idle stretches, long hold-off on request.
    initial begin : drain
        int gap;
        int taken;
        bit steady;
        taken  = 0;
        steady = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_offs_served < hold_offs_asked) begin
                pop <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_offs_served++;
            end
            if (taken % 40 == 0)
                steady = ($urandom_range(0, 2) == 0);
            gap = pick_gap(steady);
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            taken++;
        end
    end

    initial begin : stimulus
        int phase;
        int random_start;
        int phase_start;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed: counted mode, full-size buffer ---
        apply_setting(1'b0, CAP_MAX);
        // zero as a plain unit, top ASCII, smallest two-byte, top code point as a pair
        send_item(CMD_DATA, 8'h00);
        send_item(CMD_DATA, 8'h7f);
        send_item(CMD_DATA, 8'hc2);
        send_item(CMD_DATA, 8'h80);
        send_item(CMD_DATA, 8'hf4);
        send_item(CMD_DATA, 8'h8f);
        send_item(CMD_DATA, 8'hbf);
        send_item(CMD_DATA, 8'hbf);
        send_item(CMD_END, 8'h00);
        // bad continuation drops the sequence; later characters are not emitted
        send_item(CMD_DATA, 8'he2);
        send_item(CMD_DATA, 8'hff);
        send_item(CMD_DATA, 8'h41);
        send_item(CMD_END, 8'hff);
        // end command in the middle of a sequence
        send_item(CMD_DATA, 8'he2);
        send_item(CMD_DATA, 8'h82);
        send_item(CMD_END, 8'h00);
        // capacity changed mid-string: first character only counted, second emitted
        apply_setting(1'b0, 16'h0);
        send_item(CMD_DATA, 8'h41);
        apply_setting(1'b0, 16'd5);
        send_item(CMD_DATA, 8'h42);
        send_item(CMD_END, 8'h00);

        // --- directed: terminated mode, two-unit buffer ---
        apply_setting(1'b1, 16'd2);
        // terminating zero fits and rides on the closing result
        send_item(CMD_DATA, 8'h41);
        send_item(CMD_DATA, 8'h00);
        // overflow then a bad lead: invalid wins
        send_item(CMD_DATA, 8'h41);
        send_item(CMD_DATA, 8'h42);
        send_item(CMD_DATA, 8'h43);
        send_item(CMD_DATA, 8'hff);
        send_item(CMD_DATA, 8'h00);
        // end command is ignored here; zero inside a sequence closes as invalid
        send_item(CMD_END, 8'h55);
        send_item(CMD_DATA, 8'he2);
        send_item(CMD_DATA, 8'h00);

        // --- back-pressure: output held off while input keeps coming ---
        apply_setting(1'b0, CAP_MAX);
        hold_offs_asked++;
        repeat (40) send_item(CMD_DATA, 8'($urandom_range(8'h20, 8'h7e)));
        send_item(CMD_END, 8'h00);

        // --- random phases; the first few pin the register extremes ---
        phase        = 0;
        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            case (phase)
                0: apply_setting(1'b0, 16'h0);
                1: apply_setting(1'b1, CAP_MAX);
                2: apply_setting(1'b0, 16'd1);
                3: apply_setting(1'b1, 16'h0);
                default: begin
                    case ($urandom_range(0, 4))
                        0: apply_setting(1'($urandom_range(0, 1)), 16'h0);
                        1: apply_setting(1'($urandom_range(0, 1)), 16'($urandom_range(1, 4)));
                        2: apply_setting(1'($urandom_range(0, 1)), 16'($urandom_range(5, 40)));
                        3: apply_setting(1'($urandom_range(0, 1)), CAP_MAX);
                        default: apply_setting(1'($urandom_range(0, 1)), 16'($urandom));
                    endcase
                end
            endcase
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
                send_random_string();
            phase++;
        end

        wait_idle();
        $display("Run covered %0d input transactions over %0d register settings.",
                 items_sent, settings_used);
        $display("%0d result transactions compared, including one long output stall.", compared);
        if (fail_count == 0 && outstanding == 0)
            $display("utf8_to_utf16_transcoder_test: clean");
        else
            $display("utf8_to_utf16_transcoder_test: errors");
        $finish;
    end

    // watchdog
    initial begin
        #(RUN_LIMIT_NS);
        $display("utf8_to_utf16_transcoder_test: errors");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/u8u16_pkg.sv
src/u8u16_front.sv
src/u8u16_queue.sv
src/u8u16_back.sv
src/utf8_to_utf16_transcoder.sv
tb/sv/u8u16_tb_pkg.sv
tb/sv/utf8_to_utf16_transcoder_checker.sv
tb/sv/utf8_to_utf16_transcoder_test.sv
